@@ rtl/core/gwf_pkg.sv @@
package gwf_pkg;

    // Quotient and dividend width of the shared bit-serial divider
    localparam int DIV_W = 48;
    // Divisor width: 32 * width^2 needs 37 bits
    localparam int DVS_W = 37;
    // Wide force accumulator, summed before the final saturation
    localparam int FA_W  = 54;
    localparam int CNT_W = $clog2(DIV_W);

    // Register indexes on the configuration port
    localparam logic [2:0] REG_WELL_COUNT = 3'd0;
    localparam logic [2:0] REG_WELL_BASE  = 3'd1;
    localparam int         REG_WELL_REGS  = 4;

    typedef struct packed {
        logic        [15:0] depth;
        logic        [15:0] width;
        logic signed [15:0] cy;
        logic signed [15:0] cx;
    } t_well;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_IDXSET,
        ST_DIV_I,
        ST_EXPRD,
        ST_GAIN,
        ST_MXSET,
        ST_DIV_X,
        ST_ACCX,
        ST_DIV_Y,
        ST_ACCY,
        ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_SQX,
        OP_SQY,
        OP_IDXSET,
        OP_DIV,
        OP_EXPRD,
        OP_GAIN,
        OP_MXSET,
        OP_ACCX,
        OP_ACCY,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [2:0] well;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
    } t_dp_stat;

    function automatic logic signed [31:0] sat32(input logic signed [FA_W-1:0] v);
        logic signed [FA_W-1:0] hi;
        logic signed [FA_W-1:0] lo;
        hi = FA_W'(32'sh7FFF_FFFF);
        lo = -hi - FA_W'(1);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        if (v[48] != v[47]) begin
            return v[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        end
        return v[47:0];
    endfunction

endpackage

@@ rtl/core/gwf_ctrl.sv @@
module gwf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic [2:0]        i_well_num,
    input  gwf_pkg::t_dp_stat i_stat,
    output gwf_pkg::t_dp_cmd  o_cmd
);
    import gwf_pkg::*;

    t_state           r_state, n_state;
    logic [2:0]       r_well, n_well;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             last_well;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_well      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_well      <= n_well;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign last_well   = ({1'b0, r_well} + 4'd1) >= {1'b0, i_well_num};
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_well      = r_well;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd.op    = OP_NONE;
        o_cmd.well  = r_well;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_well   = '0;
                    n_state  = (i_well_num == 3'd0) ? ST_FIN : ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = ST_SQX;
            end
            ST_SQX: begin
                o_cmd.op = OP_SQX;
                n_state  = ST_SQY;
            end
            ST_SQY: begin
                o_cmd.op = OP_SQY;
                n_state  = ST_IDXSET;
            end
            ST_IDXSET: begin
                o_cmd.op = OP_IDXSET;
                n_cnt    = '0;
                n_state  = ST_DIV_I;
            end
            ST_DIV_I: begin
                // drop the well when it has no width or lies beyond the table
                if (i_stat.skip) begin
                    n_well  = r_well + 3'd1;
                    n_state = last_well ? ST_FIN : ST_DIFF;
                end else begin
                    o_cmd.op = OP_DIV;
                    n_cnt    = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_W - 1)) begin
                        n_cnt   = '0;
                        n_state = ST_EXPRD;
                    end
                end
            end
            ST_EXPRD: begin
                o_cmd.op = OP_EXPRD;
                n_state  = ST_GAIN;
            end
            ST_GAIN: begin
                o_cmd.op = OP_GAIN;
                n_state  = ST_MXSET;
            end
            ST_MXSET: begin
                o_cmd.op = OP_MXSET;
                n_cnt    = '0;
                n_state  = ST_DIV_X;
            end
            ST_DIV_X: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_ACCX;
                end
            end
            ST_ACCX: begin
                o_cmd.op = OP_ACCX;
                n_cnt    = '0;
                n_state  = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_ACCY;
                end
            end
            ST_ACCY: begin
                o_cmd.op = OP_ACCY;
                n_well   = r_well + 3'd1;
                n_state  = last_well ? ST_FIN : ST_DIFF;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op    = OP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/gwf_dp.sv @@
module gwf_dp #(
    parameter int NUM_WELLS       = 4,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gwf_pkg::t_dp_cmd          i_cmd,
    output gwf_pkg::t_dp_stat         o_stat,
    input  gwf_pkg::t_well            i_wells [NUM_WELLS],
    input  logic signed [15:0]        i_pos_x,
    input  logic signed [15:0]        i_pos_y,
    input  logic signed [31:0]        i_force_in_x,
    input  logic signed [31:0]        i_force_in_y,
    input  logic                      i_last_particle,
    output logic signed [31:0]        o_force_out_x,
    output logic signed [31:0]        o_force_out_y,
    output logic signed [31:0]        o_point_potential,
    output logic signed [47:0]        o_energy_total,
    output logic                      o_batch_end
);
    import gwf_pkg::*;

    localparam int IW   = $clog2(EXP_TABLE_DEPTH);
    localparam int WI_W = (NUM_WELLS > 1) ? $clog2(NUM_WELLS) : 1;

    typedef logic [16:0] t_tab [EXP_TABLE_DEPTH];

    // exp(-16k/D) in Q1.16: Taylor series for exp(-k/D), then squared four times
    function automatic t_tab build_tab();
        t_tab        tab;
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            x    = (64'(k) << 32) / 64'(EXP_TABLE_DEPTH);
            sum  = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int i = 1; i <= 20; i++) begin
                term = ((term * x) >> 32) / 64'(i);
                if (i[0]) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum > 64'hFFFF_FFFF) begin
                sum = 64'hFFFF_FFFF;
            end
            for (int sq = 0; sq < 4; sq++) begin
                sum = (sum * sum + (64'd1 << 31)) >> 32;
            end
            tab[k] = 17'((sum + (64'd1 << 15)) >> 16);
        end
        return tab;
    endfunction

    localparam t_tab EXP_TAB = build_tab();

    logic signed [15:0]      r_px, r_py;
    logic signed [FA_W-1:0]  r_fx, r_fy;
    logic signed [31:0]      r_pot;
    logic                    r_last;
    logic signed [47:0]      r_energy;
    logic [15:0]             r_adx, r_ady;
    logic                    r_sx, r_sy;
    logic [31:0]             r_w2;
    logic [15:0]             r_depth;
    logic                    r_wzero;
    logic [32:0]             r_r2;
    logic                    r_skip;
    logic [16:0]             r_e;
    logic [23:0]             r_g;
    logic [DIV_W-1:0]        r_dvd, r_quo;
    logic [DVS_W-1:0]        r_dvs, r_rem;

    t_well                   well;
    logic signed [16:0]      dx, dy;
    logic [DVS_W:0]          rem_sh;
    logic                    ge;
    logic signed [FA_W-1:0]  quo_ext;
    logic [32:0]             gain_prod;
    logic signed [48:0]      e_sum;
    logic signed [47:0]      e_new;
    logic [DVS_W-1:0]        w2_32;

    assign well      = i_wells[i_cmd.well[WI_W-1:0]];
    assign dx        = 17'(r_px) - 17'(well.cx);
    assign dy        = 17'(r_py) - 17'(well.cy);
    assign rem_sh    = {r_rem, r_dvd[DIV_W-1]};
    assign ge        = rem_sh >= {1'b0, r_dvs};
    assign quo_ext   = $signed({{(FA_W - DIV_W){1'b0}}, r_quo});
    assign gain_prod = 33'(r_depth) * 33'(r_e) + 33'd128;
    assign e_sum     = 49'(r_energy) + 49'(r_pot);
    assign e_new     = sat48(e_sum);
    assign w2_32     = {r_w2, 5'b0};
    assign o_stat.skip = r_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
        end else if (i_cmd.op == OP_FINISH) begin
            r_energy <= r_last ? 48'sd0 : e_new;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_px   <= i_pos_x;
                r_py   <= i_pos_y;
                r_fx   <= FA_W'(i_force_in_x);
                r_fy   <= FA_W'(i_force_in_y);
                r_last <= i_last_particle;
                r_pot  <= '0;
            end
            OP_DIFF: begin
                r_adx   <= dx[16] ? 16'(-dx) : dx[15:0];
                r_ady   <= dy[16] ? 16'(-dy) : dy[15:0];
                r_sx    <= dx[16];
                r_sy    <= dy[16];
                r_w2    <= well.width * well.width;
                r_depth <= well.depth;
                r_wzero <= (well.width == 16'd0);
            end
            OP_SQX: begin
                r_r2 <= 33'(r_adx * r_adx);
            end
            OP_SQY: begin
                r_r2 <= r_r2 + 33'(r_ady * r_ady);
            end
            OP_IDXSET: begin
                // index reaches the table end exactly when r2 >= 32*w2
                r_skip <= r_wzero || (37'(r_r2) >= w2_32);
                r_dvd  <= DIV_W'(r_r2) * DIV_W'(EXP_TABLE_DEPTH);
                r_dvs  <= w2_32;
                r_rem  <= '0;
                r_quo  <= '0;
            end
            OP_DIV: begin
                r_rem <= ge ? DVS_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DVS_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            end
            OP_EXPRD: begin
                r_e <= EXP_TAB[r_quo[IW-1:0]];
            end
            OP_GAIN: begin
                r_g <= gain_prod[31:8];
            end
            OP_MXSET: begin
                r_dvd <= {40'(r_g * r_adx), 8'b0};
                r_dvs <= DVS_W'(r_w2);
                r_rem <= '0;
                r_quo <= '0;
            end
            OP_ACCX: begin
                r_fx  <= r_sx ? r_fx + quo_ext : r_fx - quo_ext;
                r_dvd <= {40'(r_g * r_ady), 8'b0};
                r_dvs <= DVS_W'(r_w2);
                r_rem <= '0;
                r_quo <= '0;
            end
            OP_ACCY: begin
                r_fy  <= r_sy ? r_fy + quo_ext : r_fy - quo_ext;
                r_pot <= r_pot - 32'(r_g);
            end
            OP_FINISH: begin
                o_force_out_x     <= sat32(r_fx);
                o_force_out_y     <= sat32(r_fy);
                o_point_potential <= r_pot;
                o_energy_total    <= e_new;
                o_batch_end       <= r_last;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/core/gaussian_well_force_field_unit.sv @@
// Channel | Direction | Handshake                 | Payload
// input   | in        | i_in_valid / o_in_stall   | pos_x, pos_y, force_in_x/y, last_particle
// output  | out       | o_out_valid / i_out_stall | force_out_x/y, point_potential,
//         |           |                           | energy_total, batch_end
// config  | in        | APB write/read, 64-bit    | well_count @0x00, well_0..3 @0x08..0x20
//
// Each item runs through every well in turn. A contributing well uses the
// bit-serial divider for three quotients of 48 steps each; a well dropped for
// zero width or out-of-table distance does not divide.
// Reset is synchronous and clears the configuration registers, the energy total and control.
// The next item is taken while a result waits on a stalled output.
module gaussian_well_force_field_unit #(
    parameter int NUM_WELLS       = 4,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [31:0] i_force_in_x,
    input  logic signed [31:0] i_force_in_y,
    input  logic               i_last_particle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_force_out_x,
    output logic signed [31:0] o_force_out_y,
    output logic signed [31:0] o_point_potential,
    output logic signed [47:0] o_energy_total,
    output logic               o_batch_end,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import gwf_pkg::*;

    logic [2:0] r_well_count;
    t_well      r_wells [NUM_WELLS];
    logic [2:0] reg_idx;
    logic       wr_en;
    logic [2:0] well_num;
    t_dp_cmd    cmd;
    t_dp_stat   stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_well_count <= '0;
        end else if (wr_en && reg_idx == REG_WELL_COUNT) begin
            r_well_count <= pwdata[2:0];
        end
    end

    for (genvar j = 0; j < NUM_WELLS; j++) begin : g_well
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_wells[j] <= '0;
            end else if (wr_en && j < REG_WELL_REGS && reg_idx == REG_WELL_BASE + 3'(j)) begin
                r_wells[j] <= pwdata;
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_WELL_COUNT) begin
            prdata = 64'(r_well_count);
        end
        for (int j = 0; j < NUM_WELLS; j++) begin
            if (j < REG_WELL_REGS && reg_idx == REG_WELL_BASE + 3'(j)) begin
                prdata = r_wells[j];
            end
        end
    end

    assign well_num = (r_well_count > 3'(NUM_WELLS)) ? 3'(NUM_WELLS) : r_well_count;

    gwf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_well_num  (well_num),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    gwf_dp #(
        .NUM_WELLS       (NUM_WELLS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_wells           (r_wells),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_force_in_x      (i_force_in_x),
        .i_force_in_y      (i_force_in_y),
        .i_last_particle   (i_last_particle),
        .o_force_out_x     (o_force_out_x),
        .o_force_out_y     (o_force_out_y),
        .o_point_potential (o_point_potential),
        .o_energy_total    (o_energy_total),
        .o_batch_end       (o_batch_end)
    );

endmodule

@@ rtl/core/gwf_checker.sv @@
module gwf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_force_out_x,
    input logic [31:0] o_point_potential,
    input logic [47:0] o_energy_total
);

    // a result waiting on a stall stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_force_out_x) && $stable(o_energy_total))
        else $error("output payload changed under stall");

    // one item in work at a time: an accepted item closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in work");

    // wells only pull the potential down
    a_pot_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_point_potential[31] || o_point_potential == 32'd0)
        else $error("positive point potential");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind gaussian_well_force_field_unit gwf_checker u_gwf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_force_out_x     (o_force_out_x),
    .o_point_potential (o_point_potential),
    .o_energy_total    (o_energy_total)
);
